[sv/aes_pkg.sv]
// Shared types, constants and GF(2^8) helpers for the AES-128 encrypt block.
package aes_pkg;

  localparam int unsigned NumKeys = 11;
  localparam int unsigned KeyIdxW = 4;
  localparam int unsigned NumCols = 4;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_ENCRYPT = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic        mode;
    logic [3:0]  round_index;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  // Control handed to every column cell.
  typedef struct packed {
    logic load;   // take plaintext xor key 0
    logic step;   // apply one round
    logic last;   // final round: skip MixColumns
  } cell_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = xtime(x);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] v);
    logic [7:0] sq;
    logic [7:0] w;
    logic [7:0] r;
    sq = v;
    w  = 8'h01;
    for (int k = 0; k < 7; k++) begin
      sq = gf_mul(sq, sq);
      w  = gf_mul(w, sq);
    end
    r = 8'h63;
    for (int i = 0; i < 8; i++) begin
      r[i] = r[i] ^ w[i] ^ w[(i + 4) % 8] ^ w[(i + 5) % 8] ^ w[(i + 6) % 8]
           ^ w[(i + 7) % 8];
    end
    sbox_calc = r;
  endfunction

  // S-box as a constant table of 256 entries.
  typedef logic [7:0] sbox_tab_t [256];

  function automatic sbox_tab_t build_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    build_sbox = t;
  endfunction

  localparam sbox_tab_t SBox = build_sbox();

endpackage

[sv/aes128_block_encrypt_top.sv]
// Top level: AES-128 encryption, round key store, control and a row of column cells.
// Key 0 is added at the input transfer, then one round is applied per cycle for ten rounds;
//   the result holds until its transfer.
// One block in flight at a time: a new input is taken only after the last result transfers.
// Key loads give no result. Reset (rst_ni low, asynchronous) returns
//   control to idle; round keys are undefined until written.
module aes128_block_encrypt_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aes_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aes_pkg::out_item_t  out_data_o
);

  aes_pkg::state_e     state_q, state_d;
  logic [3:0]          round_q, round_d;
  logic [127:0]        key_mem [aes_pkg::NumKeys];
  logic [127:0]        rkey;
  logic [127:0]        plain;
  logic [127:0]        st;
  logic [127:0]        shifted;
  aes_pkg::cell_ctrl_t ctrl;
  logic                in_xfer;
  logic                is_enc;

  assign in_ready_o  = (state_q == aes_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign is_enc      = (in_data_i.mode == aes_pkg::MODE_ENCRYPT);
  assign out_valid_o = (state_q == aes_pkg::ST_DONE);
  assign plain       = {in_data_i.data_high, in_data_i.data_low};

  // Write a round key on a load transfer; indexes above ten drop.
  always_ff @(posedge clk_i) begin
    if (in_xfer && !is_enc && (in_data_i.round_index < 4'(aes_pkg::NumKeys))) begin
      key_mem[in_data_i.round_index] <= plain;
    end
  end

  // Key 0 on the load cycle, then the key of the current round.
  assign rkey = in_xfer ? key_mem[0] : key_mem[round_q];

  always_comb begin
    state_d   = state_q;
    round_d   = round_q;
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    ctrl.last = (round_q == 4'(aes_pkg::NumKeys - 1));
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        if (in_xfer && is_enc) begin
          ctrl.load = 1'b1;
          round_d   = 4'd1;
          state_d   = aes_pkg::ST_RUN;
        end
      end
      aes_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        // Park the round counter on key 0 after the final round.
        round_d   = ctrl.last ? 4'd0 : round_q + 4'd1;
        if (ctrl.last) state_d = aes_pkg::ST_DONE;
      end
      aes_pkg::ST_DONE: begin
        // Hold the ciphertext until the result transfer.
        if (out_ready_i) state_d = aes_pkg::ST_IDLE;
      end
      default: state_d = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::ST_IDLE;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

  // ShiftRows: byte r of column c comes from column (c+r) mod 4.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 32*c - 8*r -: 8] = st[127 - 32*((c + r) % 4) - 8*r -: 8];
      end
    end
  end

  for (genvar c = 0; c < aes_pkg::NumCols; c++) begin : g_col
    aes_col_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .plain_i (plain[127 - 32*c -: 32]),
      .key_i   (rkey[127 - 32*c -: 32]),
      .shift_i (shifted[127 - 32*c -: 32]),
      .col_o   (st[127 - 32*c -: 32])
    );
  end

  assign out_data_o.cipher_high = st[127:64];
  assign out_data_o.cipher_low  = st[63:0];

  // No input transfer while a block is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != aes_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("input ready while busy");

  // A result stays until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped before transfer");

  // The round loop ends at the last key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aes_pkg::ST_RUN) |-> (round_q >= 4'd1 && round_q <= 4'd10))
    else $error("round count out of range");

endmodule

[sv/aes_col_cell.sv]
// One state column: receives its ShiftRows inputs from neighbor columns each round.
module aes_col_cell (
  input  logic                  clk_i,
  input  aes_pkg::cell_ctrl_t   ctrl_i,
  input  logic [31:0]           plain_i,
  input  logic [31:0]           key_i,
  input  logic [31:0]           shift_i,   // bytes r of column c+r, already gathered
  output logic [31:0]           col_o
);

  logic [31:0] col_q, col_d;
  logic [7:0]  s0, s1, s2, s3;
  logic [31:0] mixed;

  always_comb begin
    s0 = aes_pkg::SBox[shift_i[31:24]];
    s1 = aes_pkg::SBox[shift_i[23:16]];
    s2 = aes_pkg::SBox[shift_i[15:8]];
    s3 = aes_pkg::SBox[shift_i[7:0]];
    mixed[31:24] = aes_pkg::xtime(s0) ^ aes_pkg::xtime(s1) ^ s1 ^ s2 ^ s3;
    mixed[23:16] = s0 ^ aes_pkg::xtime(s1) ^ aes_pkg::xtime(s2) ^ s2 ^ s3;
    mixed[15:8]  = s0 ^ s1 ^ aes_pkg::xtime(s2) ^ aes_pkg::xtime(s3) ^ s3;
    mixed[7:0]   = aes_pkg::xtime(s0) ^ s0 ^ s1 ^ s2 ^ aes_pkg::xtime(s3);
    col_d = col_q;
    if (ctrl_i.load) begin
      col_d = plain_i ^ key_i;
    end else if (ctrl_i.step) begin
      col_d = (ctrl_i.last ? {s0, s1, s2, s3} : mixed) ^ key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the AES-128 block encryption top level.
`timescale 1ns / 1ps
module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  aes_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  aes_pkg::out_item_t out_data_o;

  aes128_block_encrypt_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: our own copy of the round key store and an S-box table.
  logic [127:0]       key_mirror [aes_pkg::NumKeys];
  logic [7:0]         sub_tab [256];
  aes_pkg::out_item_t cipher_fifo [$];
  int                 err_count = 0;
  int                 cipher_seen = 0;
  int                 items_sent = 0;
  int                 hold_cycles = 0;   // forced receiver stall, counted down by the sink
  bit                 sink_calm = 1'b0;  // no random stalls when set

  function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1B) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [7:0] sub_value(logic [7:0] v);
    logic [7:0] sq;
    logic [7:0] w;
    logic [7:0] r;
    sq = v;
    w = 8'h01;
    // x^254 by repeated squaring; zero stays zero
    for (int k = 0; k < 7; k++) begin
      sq = field_mul(sq, sq);
      w = field_mul(w, sq);
    end
    r = 8'h63;
    for (int i = 0; i < 8; i++)
      r[i] ^= w[i] ^ w[(i + 4) % 8] ^ w[(i + 5) % 8] ^ w[(i + 6) % 8] ^ w[(i + 7) % 8];
    return r;
  endfunction

  // Byte k of the state sits at bits 127-8k of the 128-bit word.
  function automatic logic [127:0] encrypt_block(logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ key_mirror[0][127 - 8 * i -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[c * 4 + r] = sub_tab[s[((c + r) % 4) * 4 + r]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
          t[c * 4]     = field_mul(a0, 8'h02) ^ field_mul(a1, 8'h03) ^ a2 ^ a3;
          t[c * 4 + 1] = a0 ^ field_mul(a1, 8'h02) ^ field_mul(a2, 8'h03) ^ a3;
          t[c * 4 + 2] = a0 ^ a1 ^ field_mul(a2, 8'h02) ^ field_mul(a3, 8'h03);
          t[c * 4 + 3] = field_mul(a0, 8'h03) ^ a1 ^ a2 ^ field_mul(a3, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ key_mirror[rnd][127 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Offer one item at the falling edge, hold it until the transfer, then update the predictor.
  // Valid stays up into the next item when there is no gap; drop it only for a gap.
  task automatic send_item(aes_pkg::mode_e m, logic [3:0] idx, logic [127:0] data, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= '{mode: m, round_index: idx, data_high: data[127:64], data_low: data[63:0]};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (m == aes_pkg::MODE_LOAD) begin
      if (idx < aes_pkg::NumKeys) key_mirror[idx] = data;
    end else begin
      cipher_fifo.push_back(encrypt_block(data));
    end
    @(negedge clk_i);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  task automatic load_all_keys(int gap_mode);
    for (int i = 0; i < aes_pkg::NumKeys; i++)
      send_item(aes_pkg::MODE_LOAD, 4'(i), rand128(), gap_mode ? gap_len() : 0);
  endtask

  // Sink: drive ready at the falling edge, check each transfer seen at the rising edge.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (sink_calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_fifo.size() == 0) begin
        $display("unexpected cipher transfer %h", out_data_o);
        err_count++;
      end else begin
        automatic aes_pkg::out_item_t w = cipher_fifo.pop_front();
        if (out_data_o.cipher_high !== w.cipher_high)
          report_mismatch("cipher_high", out_data_o.cipher_high, w.cipher_high);
        if (out_data_o.cipher_low !== w.cipher_low)
          report_mismatch("cipher_low", out_data_o.cipher_low, w.cipher_low);
        cipher_seen++;
      end
    end
  end

  // Standard FIPS-197 vector plus edge keys and plaintexts.
  task automatic test_directed();
    logic [127:0] ks [11];
    ks = '{128'h000102030405060708090a0b0c0d0e0f, 128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
           128'hb692cf0b643dbdf1be9bc5006830b3fe, 128'hb6ff744ed2c2c9bf6c590cbf0469bf41,
           128'h47f7f7bc95353e03f96c32bcfd058dfd, 128'h3caaa3e8a99f9deb50f3af57adf622aa,
           128'h5e390f7df7a69296a7553dc10aa31f6b, 128'h14f9701ae35fe28c440adf4d4ea9c026,
           128'h47438735a41c65b9e016baf4aebf7ad2, 128'h549932d1f08557681093ed9cbe2c974e,
           128'h13111d7fe3944a17f307a78b4d2b30c5};
    sink_calm = 1'b1;
    for (int i = 0; i < aes_pkg::NumKeys; i++) send_item(aes_pkg::MODE_LOAD, 4'(i), ks[i], 0);
    send_item(aes_pkg::MODE_ENCRYPT, 4'd0, 128'h00112233445566778899aabbccddeeff, 0);
    send_item(aes_pkg::MODE_ENCRYPT, 4'd15, '0, 0);
    send_item(aes_pkg::MODE_ENCRYPT, 4'd5, '1, 1);
    // out-of-range indexes must leave the store untouched
    send_item(aes_pkg::MODE_LOAD, 4'd11, '1, 0);
    send_item(aes_pkg::MODE_LOAD, 4'd15, '1, 0);
    send_item(aes_pkg::MODE_ENCRYPT, 4'd0, 128'h00112233445566778899aabbccddeeff, 0);
    for (int i = 0; i < aes_pkg::NumKeys; i++)
      send_item(aes_pkg::MODE_LOAD, 4'(i), i[0] ? '1 : '0, 0);
    send_item(aes_pkg::MODE_ENCRYPT, 4'd0, '0, 0);
    send_item(aes_pkg::MODE_ENCRYPT, 4'd0, 128'h8000000000000000_0000000000000001, 0);
    sink_calm = 1'b0;
  endtask

  // Mostly encrypts with random content, key reloads and stray bad-index loads mixed in.
  task automatic test_random(int count);
    logic [3:0] idx;
    load_all_keys(1);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: send_item(aes_pkg::MODE_LOAD, 4'($urandom_range(0, 10)), rand128(), gap_len());
        1: begin
          idx = 4'($urandom_range(0, 15));
          send_item(aes_pkg::MODE_LOAD, idx, rand128(), gap_len());
        end
        default: send_item(aes_pkg::MODE_ENCRYPT, 4'($urandom()), rand128(), gap_len());
      endcase
    end
  endtask

  // Stall the receiver for a long stretch while back-to-back items keep arriving.
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int n = 0; n < 30; n++) send_item(aes_pkg::MODE_ENCRYPT, 4'd0, rand128(), 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sub_tab = '{default: 8'h00};
    for (int i = 0; i < 256; i++) sub_tab[i] = sub_value(8'(i));
    test_directed();
    test_backpressure();
    test_random(1800);
    in_valid_i <= 1'b0;
    // drain, then give the round loop time to show any stray result
    while (cipher_fifo.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d items: key loads, bad indexes, FIPS vector, random blocks", items_sent);
    $display("%0d ciphertexts checked, long receiver stall included", cipher_seen);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
